FILE: sv/ots_pkg.sv
package ots_pkg;

   localparam int HistoryDepth = 256;
   localparam int DocCapacity = 4096;

   localparam logic [2:0] StatusApplied = 3'd0;
   localparam logic [2:0] StatusDropped = 3'd1;
   localparam logic [2:0] StatusStale = 3'd2;
   localparam logic [2:0] StatusFull = 3'd3;
   localparam logic [2:0] StatusBadPos = 3'd4;

   localparam logic CmdInsert = 1'b0;
   localparam logic CmdDelete = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_HREAD,
      ST_HWAIT,
      ST_HAPPLY,
      ST_DECIDE,
      ST_SREAD,
      ST_SWAIT,
      ST_SWRITE,
      ST_FINAL,
      ST_OUT
   } state_type;

   // history entry: kind, 13-bit signed position, client
   typedef struct packed {
      logic kind;
      logic signed [12:0] pos;
      logic [15:0] client;
   } hist_type;

   // one position step against a history entry
   function automatic logic signed [13:0] shift_against(
      input logic kind,
      input logic signed [13:0] pos,
      input logic [15:0] client,
      input hist_type h
   );
      logic signed [13:0] hp;
      logic signed [13:0] res;
      begin
         hp = {h.pos[12], h.pos};
         res = pos;
         if (kind == CmdInsert && h.kind == CmdInsert) begin
            if (pos > hp || (pos == hp && client > h.client)) res = pos + 14'sd1;
         end else if (kind == CmdDelete && h.kind == CmdDelete) begin
            if (pos > hp) res = pos - 14'sd1;
            else if (pos == hp) res = -14'sd1;
         end else if (kind == CmdInsert) begin
            if (pos > hp) res = pos - 14'sd1;
         end else begin
            if (pos >= hp) res = pos + 14'sd1;
         end
         return res;
      end
   endfunction

endpackage

FILE: sv/ot_edit_sequencer_unit.sv
// ot_edit_sequencer_unit: single-character insert/delete transform sequencer
//
// req_ channel: one edit item (command, base revision, position, character,
// client id), taken when req_valid is high and req_stall is low. The block
// takes one item at a time; req_stall is high from acceptance until the
// result item has been taken on the rsp_ channel.
// rsp_ channel: one result item per edit, held in an output register until
// taken (rsp_valid high, rsp_stall low). A stalled result holds steady.
// The result waits on a history walk over D = revisions between base and
// current (one history memory read each, D up to HISTORY_DEPTH) and on a
// shift of S characters in the document memory (S below DOC_CAPACITY), both
// paced by the single read/write port of each memory. Rejected edits skip
// the shift and return sooner; a stale base skips the history walk too.
// Reset: revision, history fill count and text length clear at once; the
// memories hold no reset values and unwritten entries are never read.
module ot_edit_sequencer_unit #(
   parameter int HISTORY_DEPTH = ots_pkg::HistoryDepth,
   parameter int DOC_CAPACITY = ots_pkg::DocCapacity
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_command,
   input  logic [31:0] req_base_revision,
   input  logic [11:0] req_edit_position,
   input  logic [7:0] req_character,
   input  logic [15:0] req_client_id,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_out_kind,
   output logic [31:0] rsp_assigned_revision,
   output logic signed [12:0] rsp_final_position,
   output logic [7:0] rsp_out_character,
   output logic [15:0] rsp_out_client,
   output logic [2:0] rsp_status,
   output logic [12:0] rsp_document_length
);
   localparam int Hw = $clog2(HISTORY_DEPTH > 1 ? HISTORY_DEPTH : 2);
   localparam int Dw = $clog2(DOC_CAPACITY);
   localparam int Fw = $clog2(HISTORY_DEPTH + 1);
   localparam int Lw = $clog2(DOC_CAPACITY + 1);
   localparam logic [Fw-1:0] FillMax = Fw'(HISTORY_DEPTH);
   localparam logic [Lw-1:0] CapLen = Lw'(DOC_CAPACITY);

   ots_pkg::state_type state_ff, state_in;

   logic [31:0] rev_ff, rev_in;
   logic [Fw-1:0] fill_ff, fill_in;
   logic [Lw-1:0] len_ff, len_in;

   logic kind_ff, kind_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] dist_ff, dist_in;
   logic signed [13:0] pos_ff, pos_in;
   logic [7:0] ch_ff, ch_in;
   logic [15:0] client_ff, client_in;
   logic [12:0] orig_ff, orig_in;
   logic [Lw-1:0] k_ff, k_in;
   logic [2:0] status_ff, status_in;
   logic signed [12:0] fpos_ff, fpos_in;

   ots_pkg::hist_type h_rd, h_wr;
   logic h_we;
   logic [Hw-1:0] h_raddr, h_waddr;
   logic [7:0] d_rd, d_wdata;
   logic d_we;
   logic [Dw-1:0] d_raddr, d_waddr;

   ots_history #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_hist (
      .clock(clock), .rd_addr(h_raddr), .rd_data(h_rd),
      .wr_en(h_we), .wr_addr(h_waddr), .wr_data(h_wr)
   );

   ots_document #(.DOC_CAPACITY(DOC_CAPACITY)) u_doc (
      .clock(clock), .rd_addr(d_raddr), .rd_data(d_rd),
      .wr_en(d_we), .wr_addr(d_waddr), .wr_data(d_wdata)
   );

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ots_pkg::ST_IDLE;
         rev_ff <= '0;
         fill_ff <= '0;
         len_ff <= '0;
      end else begin
         state_ff <= state_in;
         rev_ff <= rev_in;
         fill_ff <= fill_in;
         len_ff <= len_in;
      end
      kind_ff <= kind_in;
      base_ff <= base_in;
      dist_ff <= dist_in;
      pos_ff <= pos_in;
      ch_ff <= ch_in;
      client_ff <= client_in;
      orig_ff <= orig_in;
      k_ff <= k_in;
      status_ff <= status_in;
      fpos_ff <= fpos_in;
   end

   logic [Lw-1:0] pos_len;
   assign pos_len = Lw'(pos_ff[12:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ots_pkg::ST_IDLE: if (req_valid) state_in = ots_pkg::ST_HREAD;
         ots_pkg::ST_HREAD: begin
            if (dist_ff > 32'(fill_ff)) state_in = ots_pkg::ST_OUT;
            else if (dist_ff == 32'd0 || pos_ff < 0) state_in = ots_pkg::ST_DECIDE;
            else state_in = ots_pkg::ST_HWAIT;
         end
         ots_pkg::ST_HWAIT: state_in = ots_pkg::ST_HAPPLY;
         ots_pkg::ST_HAPPLY: state_in = ots_pkg::ST_HREAD;
         ots_pkg::ST_DECIDE: begin
            if (kind_ff == ots_pkg::CmdInsert) begin
               if (len_ff >= CapLen || pos_len > len_ff) state_in = ots_pkg::ST_OUT;
               else state_in = ots_pkg::ST_SREAD;
            end else begin
               if (pos_ff < 0 || pos_len >= len_ff) state_in = ots_pkg::ST_FINAL;
               else state_in = ots_pkg::ST_SREAD;
            end
         end
         ots_pkg::ST_SREAD: begin
            if (kind_ff == ots_pkg::CmdInsert) begin
               if (k_ff > pos_len) state_in = ots_pkg::ST_SWAIT;
               else state_in = ots_pkg::ST_FINAL;
            end else begin
               if (k_ff + Lw'(1) < len_ff) state_in = ots_pkg::ST_SWAIT;
               else state_in = ots_pkg::ST_FINAL;
            end
         end
         ots_pkg::ST_SWAIT: state_in = ots_pkg::ST_SWRITE;
         ots_pkg::ST_SWRITE: state_in = ots_pkg::ST_SREAD;
         ots_pkg::ST_FINAL: state_in = ots_pkg::ST_OUT;
         ots_pkg::ST_OUT: if (!rsp_stall) state_in = ots_pkg::ST_IDLE;
         default: state_in = ots_pkg::ST_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      rev_in = rev_ff;
      fill_in = fill_ff;
      len_in = len_ff;
      kind_in = kind_ff;
      base_in = base_ff;
      dist_in = dist_ff;
      pos_in = pos_ff;
      ch_in = ch_ff;
      client_in = client_ff;
      orig_in = orig_ff;
      k_in = k_ff;
      status_in = status_ff;
      fpos_in = fpos_ff;
      h_raddr = base_ff[Hw-1:0];
      h_we = 1'b0;
      h_waddr = rev_ff[Hw-1:0];
      h_wr = '{kind: kind_ff, pos: fpos_ff, client: client_ff};
      d_raddr = (kind_ff == ots_pkg::CmdInsert) ? Dw'(k_ff - Lw'(1)) : Dw'(k_ff + Lw'(1));
      d_we = 1'b0;
      d_waddr = Dw'(k_ff);
      d_wdata = d_rd;
      case (state_ff)
         ots_pkg::ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_command;
               base_in = req_base_revision;
               dist_in = rev_ff - req_base_revision;
               pos_in = 14'(req_edit_position);
               orig_in = 13'(req_edit_position);
               ch_in = req_character;
               client_in = req_client_id;
            end
         end
         ots_pkg::ST_HREAD: begin
            if (dist_ff > 32'(fill_ff)) begin
               status_in = ots_pkg::StatusStale;
               fpos_in = $signed(orig_ff);
            end
         end
         ots_pkg::ST_HAPPLY: begin
            if (h_rd.pos != -13'sd1)
               pos_in = ots_pkg::shift_against(kind_ff, pos_ff, client_ff, h_rd);
            base_in = base_ff + 32'd1;
            dist_in = dist_ff - 32'd1;
         end
         ots_pkg::ST_DECIDE: begin
            k_in = (kind_ff == ots_pkg::CmdInsert) ? len_ff : pos_len;
            fpos_in = pos_ff[12:0];
            if (kind_ff == ots_pkg::CmdInsert) begin
               if (len_ff >= CapLen) begin
                  status_in = ots_pkg::StatusFull;
                  fpos_in = $signed(orig_ff);
               end else if (pos_len > len_ff) begin
                  status_in = ots_pkg::StatusBadPos;
                  fpos_in = $signed(orig_ff);
               end else status_in = ots_pkg::StatusApplied;
            end else if (pos_ff < 0 || pos_len >= len_ff) begin
               status_in = ots_pkg::StatusDropped;
               fpos_in = -13'sd1;
            end else status_in = ots_pkg::StatusApplied;
         end
         ots_pkg::ST_SWRITE: begin
            d_we = 1'b1;
            k_in = (kind_ff == ots_pkg::CmdInsert) ? k_ff - Lw'(1) : k_ff + Lw'(1);
         end
         ots_pkg::ST_FINAL: begin
            // place the character or shrink, then log the edit
            if (status_ff == ots_pkg::StatusApplied) begin
               if (kind_ff == ots_pkg::CmdInsert) begin
                  d_we = 1'b1;
                  d_waddr = Dw'(pos_len);
                  d_wdata = ch_ff;
                  len_in = len_ff + Lw'(1);
               end else len_in = len_ff - Lw'(1);
            end
            h_we = 1'b1;
            rev_in = rev_ff + 32'd1;
            if (fill_ff < FillMax) fill_in = fill_ff + Fw'(1);
         end
         default: ;
      endcase
   end

   assign req_stall = (state_ff != ots_pkg::ST_IDLE);
   assign rsp_valid = (state_ff == ots_pkg::ST_OUT);
   assign rsp_out_kind = kind_ff;
   assign rsp_assigned_revision = (status_ff == ots_pkg::StatusApplied ||
                                   status_ff == ots_pkg::StatusDropped) ? rev_ff - 32'd1 : rev_ff;
   assign rsp_final_position = fpos_ff;
   assign rsp_out_character = ch_ff;
   assign rsp_out_client = client_ff;
   assign rsp_status = status_ff;
   assign rsp_document_length = 13'(len_ff);
endmodule

FILE: sv/ots_history.sv
module ots_history #(
   parameter int HISTORY_DEPTH = ots_pkg::HistoryDepth
) (
   input  logic clock,
   input  logic [$clog2(HISTORY_DEPTH > 1 ? HISTORY_DEPTH : 2)-1:0] rd_addr,
   output ots_pkg::hist_type rd_data,
   input  logic wr_en,
   input  logic [$clog2(HISTORY_DEPTH > 1 ? HISTORY_DEPTH : 2)-1:0] wr_addr,
   input  ots_pkg::hist_type wr_data
);
   localparam int Aw = $clog2(HISTORY_DEPTH > 1 ? HISTORY_DEPTH : 2);
   localparam int Dp = 1 << Aw;
   ots_pkg::hist_type mem [Dp];

   // single write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/ots_document.sv
module ots_document #(
   parameter int DOC_CAPACITY = ots_pkg::DocCapacity
) (
   input  logic clock,
   input  logic [$clog2(DOC_CAPACITY)-1:0] rd_addr,
   output logic [7:0] rd_data,
   input  logic wr_en,
   input  logic [$clog2(DOC_CAPACITY)-1:0] wr_addr,
   input  logic [7:0] wr_data
);
   logic [7:0] mem [DOC_CAPACITY];

   // character store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

FILE: sv/ots_checker.sv
module ots_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [2:0] rsp_status,
   input logic [12:0] rsp_document_length,
   input logic [31:0] rsp_assigned_revision
);
   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_assigned_revision) && $stable(rsp_document_length))
      else $error("result changed while stalled");

   // no new item taken while a result is waiting
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while result pending");

   // one item at a time: busy right after an accepted item
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while busy");

   // status code in range
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'd4)
      else $error("bad status code");

   // length never exceeds capacity
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_document_length <= 13'd4096)
      else $error("document length over capacity");
endmodule

bind ot_edit_sequencer_unit ots_checker u_ots_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
   .rsp_document_length(rsp_document_length),
   .rsp_assigned_revision(rsp_assigned_revision)
);

FILE: tb/sv/ot_edit_sequencer_unit_test.sv
`timescale 1ns / 1ps

module ot_edit_sequencer_unit_test;

   localparam int CycleLimit = 10000000;

   // an edit result as the block reports it
   typedef struct {
      logic kind;
      logic [31:0] revision;
      logic signed [12:0] position;
      logic [7:0] char_value;
      logic [15:0] client;
      logic [2:0] status;
      logic [12:0] length;
   } edit_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = ots_pkg::CmdInsert;
   logic [31:0] req_base_revision = '0;
   logic [11:0] req_edit_position = '0;
   logic [7:0] req_character = '0;
   logic [15:0] req_client_id = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_out_kind;
   logic [31:0] rsp_assigned_revision;
   logic signed [12:0] rsp_final_position;
   logic [7:0] rsp_out_character;
   logic [15:0] rsp_out_client;
   logic [2:0] rsp_status;
   logic [12:0] rsp_document_length;

   // shadow copy of the sequencer state
   logic [31:0] doc_revision;
   int history_count;
   int text_len;
   logic hist_kind [ots_pkg::HistoryDepth];
   int hist_pos [ots_pkg::HistoryDepth];
   logic [15:0] hist_client [ots_pkg::HistoryDepth];

   edit_result_type pending_results [$];
   bit quiet = 1'b0;
   int stall_left = 0;
   int cycle_count = 0;
   int mismatches = 0;
   int results_seen = 0;
   int items_sent = 0;

   ot_edit_sequencer_unit uut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // transform an edit against the history, apply it, return the result
   function automatic edit_result_type apply_edit(logic kind, logic [31:0] base,
         logic [11:0] position, logic [7:0] char_value, logic [15:0] client);
      edit_result_type r;
      logic [31:0] span;
      logic [31:0] slot;
      int idx;
      int p;
      int hp;
      r.kind = kind;
      r.revision = doc_revision;
      r.position = $signed({1'b0, position});
      r.char_value = char_value;
      r.client = client;
      span = doc_revision - base;
      p = position;
      if (span > 32'(history_count)) begin
         r.status = ots_pkg::StatusStale;
      end else begin
         for (int i = 0; 32'(i) < span && p != -1; i++) begin
            slot = base + 32'(i);
            idx = int'(slot % 32'(ots_pkg::HistoryDepth));
            hp = hist_pos[idx];
            if (hp == -1) continue;
            if (kind == ots_pkg::CmdInsert && hist_kind[idx] == ots_pkg::CmdInsert) begin
               if (p > hp || (p == hp && client > hist_client[idx])) p++;
            end else if (kind == ots_pkg::CmdDelete && hist_kind[idx] == ots_pkg::CmdDelete) begin
               if (p > hp) p--;
               else if (p == hp) p = -1;
            end else if (kind == ots_pkg::CmdInsert) begin
               if (p > hp) p--;
            end else begin
               if (p >= hp) p++;
            end
         end
         if (kind == ots_pkg::CmdInsert) begin
            if (text_len >= ots_pkg::DocCapacity) r.status = ots_pkg::StatusFull;
            else if (p > text_len) r.status = ots_pkg::StatusBadPos;
            else begin
               text_len++;
               r.status = ots_pkg::StatusApplied;
            end
         end else begin
            if (p < 0 || p >= text_len) begin
               p = -1;
               r.status = ots_pkg::StatusDropped;
            end else begin
               text_len--;
               r.status = ots_pkg::StatusApplied;
            end
         end
         // record in the ring history when a revision is consumed
         if (r.status == ots_pkg::StatusApplied || r.status == ots_pkg::StatusDropped) begin
            idx = int'(doc_revision % 32'(ots_pkg::HistoryDepth));
            hist_kind[idx] = kind;
            hist_pos[idx] = p;
            hist_client[idx] = client;
            if (history_count < ots_pkg::HistoryDepth) history_count++;
            doc_revision++;
            r.position = 13'(p);
         end
      end
      r.length = 13'(text_len);
      return r;
   endfunction

   // send one edit item, with an optional random gap first
   task automatic send_edit(logic kind, logic [31:0] base, logic [11:0] position,
         logic [7:0] char_value, logic [15:0] client);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= kind;
      req_base_revision <= base;
      req_edit_position <= position;
      req_character <= char_value;
      req_client_id <= client;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(apply_edit(kind, base, position, char_value, client));
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // result side stalls in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // compare each result item with the oldest expectation
   always @(posedge clock) begin
      edit_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycle_count);
         end else begin
            e = pending_results.pop_front();
            if (rsp_out_kind !== e.kind || rsp_assigned_revision !== e.revision ||
                  rsp_final_position !== e.position || rsp_out_character !== e.char_value ||
                  rsp_out_client !== e.client || rsp_status !== e.status ||
                  rsp_document_length !== e.length) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp kind %0d rev %0d pos %0d chr %0d cli %0d st %0d len %0d",
                     e.kind, e.revision, e.position, e.char_value, e.client, e.status,
                     e.length, "; got kind %0d rev %0d pos %0d chr %0d cli %0d st %0d len %0d",
                     rsp_out_kind, rsp_assigned_revision, rsp_final_position,
                     rsp_out_character, rsp_out_client, rsp_status, rsp_document_length);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // corner cases on a small document
   task automatic test_directed();
      logic [31:0] r0;
      send_edit(ots_pkg::CmdDelete, doc_revision, 12'd0, 8'h00, 16'h0000);   // delete on empty
      send_edit(ots_pkg::CmdInsert, doc_revision, 12'd1, 8'hff, 16'hffff);   // insert past end
      send_edit(ots_pkg::CmdInsert, doc_revision, 12'd0, 8'h00, 16'h0000);
      send_edit(ots_pkg::CmdInsert, doc_revision, 12'd1, 8'hff, 16'hffff);
      send_edit(ots_pkg::CmdInsert, doc_revision, 12'd4095, 8'h5a, 16'h1234);
      send_edit(ots_pkg::CmdInsert, doc_revision + 32'd1, 12'd0, 8'h11, 16'h0001); // future base
      send_edit(ots_pkg::CmdInsert, 32'hffff_ffff, 12'd0, 8'h11, 16'h0001);        // stale base
      // concurrent inserts at one position, tie broken by client
      r0 = doc_revision;
      send_edit(ots_pkg::CmdInsert, r0, 12'd1, 8'h41, 16'h0005);
      send_edit(ots_pkg::CmdInsert, r0, 12'd1, 8'h42, 16'h0009);
      send_edit(ots_pkg::CmdInsert, r0, 12'd1, 8'h43, 16'h0002);
      // concurrent deletes of one character collide
      r0 = doc_revision;
      send_edit(ots_pkg::CmdDelete, r0, 12'd2, 8'h00, 16'h0003);
      send_edit(ots_pkg::CmdDelete, r0, 12'd2, 8'h00, 16'h0004);
      send_edit(ots_pkg::CmdInsert, r0, 12'd3, 8'h44, 16'h0007);
      send_edit(ots_pkg::CmdDelete, r0, 12'd0, 8'h00, 16'h0008);
      send_edit(ots_pkg::CmdDelete, doc_revision, 12'd4095, 8'h00, 16'hffff);  // delete past end
      // sender holds off until everything is back
      wait_for_results();
      send_edit(ots_pkg::CmdDelete, doc_revision - 32'd3, 12'd1, 8'h00, 16'h0001);
   endtask

   // random edits, mostly on recent bases
   task automatic test_random();
      logic [31:0] base;
      logic kind;
      int pick;
      int pos;
      for (int n = 0; n < 105; n++) begin
         if (n == 85) begin
            wait_for_results();
            quiet = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick == 0) base = $urandom();
         else if (pick == 1) base = doc_revision + $urandom_range(1, 4);
         else if (pick < 4) base = doc_revision - $urandom_range(0, history_count);
         else base = doc_revision - $urandom_range(0, history_count < 6 ? history_count : 6);
         kind = ($urandom_range(0, 9) < 6) ? ots_pkg::CmdInsert : ots_pkg::CmdDelete;
         pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                            : $urandom_range(0, text_len + 1);
         send_edit(kind, base, pos[11:0], 8'($urandom_range(0, 255)),
            16'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 65535)));
      end
   endtask

   // walks over the whole recorded history and bases just past it
   task automatic test_deep_history();
      send_edit(ots_pkg::CmdInsert, doc_revision - 32'(history_count), 12'd5, 8'h78, 16'h0002);
      send_edit(ots_pkg::CmdDelete, doc_revision - 32'(history_count) - 32'd1, 12'd0, 8'h00,
         16'h0003);
      send_edit(ots_pkg::CmdDelete, doc_revision - 32'(history_count), 12'd0, 8'h00, 16'h0004);
      send_edit(ots_pkg::CmdDelete, doc_revision, 12'd4095, 8'h00, 16'h0005);
      send_edit(ots_pkg::CmdInsert, doc_revision - 32'd2, 12'd4095, 8'h79, 16'hffff);
   endtask

   initial begin
      doc_revision = '0;
      history_count = 0;
      text_len = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_deep_history();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d edits: directed corners, random transforms, deep history walks",
         items_sent);
      $display("results checked %0d, mismatches %0d", results_seen, mismatches);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
